// ----- rtl/trs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_pkg
// Shared constants, types and fixed-point helpers of the model matrix builder.
// ----------------------------------------------------------------------------
package trs_pkg;

   localparam int NTERMS = 10;
   // stage 0 plus three stages for each series term
   localparam int SC_LAT = 1 + 3 * NTERMS;
   // sine/cosine stages, then quaternion and matrix stages
   localparam int NSTG   = SC_LAT + 7;

   localparam logic signed [31:0] QONE = 32'sd268435456;
   localparam logic [63:0] RcpBase = 64'h0000_0001_0000_0000;

   localparam logic [63:0] SIN_DIV [1:NTERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};
   localparam logic [63:0] COS_DIV [1:NTERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
   localparam logic [63:0] SIN_RCP [1:NTERMS] = '{
      RcpBase / 64'd6, RcpBase / 64'd20, RcpBase / 64'd42, RcpBase / 64'd72,
      RcpBase / 64'd110, RcpBase / 64'd156, RcpBase / 64'd210, RcpBase / 64'd272,
      RcpBase / 64'd342, RcpBase / 64'd420};
   localparam logic [63:0] COS_RCP [1:NTERMS] = '{
      RcpBase / 64'd2, RcpBase / 64'd12, RcpBase / 64'd30, RcpBase / 64'd56,
      RcpBase / 64'd90, RcpBase / 64'd132, RcpBase / 64'd182, RcpBase / 64'd240,
      RcpBase / 64'd306, RcpBase / 64'd380};

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [23:0] scale_x;
      logic signed [23:0] scale_y;
      logic signed [23:0] scale_z;
   } pay_type;

   // divide by 2^28, truncating toward zero
   function automatic logic signed [63:0] qdiv28(input logic signed [63:0] p);
      logic signed [63:0] q;
      q = p >>> 28;
      if (p[63] && (p[27:0] != 28'd0)) begin
         q = q + 64'sd1;
      end
      return q;
   endfunction

   // Q.28 product with truncation toward zero
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return 32'(qdiv28(p));
   endfunction

endpackage

// ----- rtl/trs_sincos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_sincos
// Pipelined Taylor series of sine and cosine of the half angle, Q.28 out.
// ----------------------------------------------------------------------------
module trs_sincos import trs_pkg::*; (
   input  logic                clock,
   input  logic [SC_LAT-1:0]   adv,
   input  logic signed [15:0]  angle,
   output logic signed [31:0]  sin_q,
   output logic signed [31:0]  cos_q
);

   logic signed [31:0] ts_ff [0:NTERMS];
   logic signed [31:0] tc_ff [0:NTERMS];
   logic signed [31:0] s_ff  [0:NTERMS];
   logic signed [31:0] c_ff  [0:NTERMS];
   logic [30:0]        h2_ff [0:NTERMS];

   logic signed [63:0] ps_ff [1:NTERMS];
   logic signed [63:0] pc_ff [1:NTERMS];
   logic signed [31:0] sa_ff [1:NTERMS];
   logic signed [31:0] ca_ff [1:NTERMS];
   logic [30:0]        ha_ff [1:NTERMS];

   logic [31:0]        qs_ff [1:NTERMS];
   logic [31:0]        qc_ff [1:NTERMS];
   logic [31:0]        es_ff [1:NTERMS];
   logic [31:0]        ec_ff [1:NTERMS];
   logic               ns_ff [1:NTERMS];
   logic               nc_ff [1:NTERMS];
   logic signed [31:0] sb_ff [1:NTERMS];
   logic signed [31:0] cb_ff [1:NTERMS];
   logic [30:0]        hb_ff [1:NTERMS];

   logic signed [31:0] ang_w;
   logic signed [31:0] ang_sq;

   assign ang_w  = 32'(angle);
   assign ang_sq = ang_w * ang_w;

   // h = angle * 2^14, and h*h/2^28 is exactly angle squared
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ts_ff[0] <= {{2{angle[15]}}, angle, 14'd0};
         s_ff[0]  <= {{2{angle[15]}}, angle, 14'd0};
         tc_ff[0] <= QONE;
         c_ff[0]  <= QONE;
         h2_ff[0] <= ang_sq[30:0];
      end
   end

   for (genvar k = 1; k <= NTERMS; k++) begin : g_term
      logic signed [63:0] h2w;
      logic [63:0]        mag_s;
      logic [63:0]        mag_c;
      logic [31:0]        qs_in;
      logic [31:0]        qc_in;
      logic [63:0]        es_prod;
      logic [63:0]        ec_prod;
      logic [63:0]        rs_prod;
      logic [63:0]        rc_prod;
      logic [31:0]        rem_s;
      logic [31:0]        rem_c;
      logic [31:0]        quo_s;
      logic [31:0]        quo_c;
      logic signed [31:0] ts_in;
      logic signed [31:0] tc_in;

      assign h2w     = $signed({33'd0, h2_ff[k-1]});
      assign mag_s   = ps_ff[k][63] ? 64'(-ps_ff[k]) : 64'(ps_ff[k]);
      assign mag_c   = pc_ff[k][63] ? 64'(-pc_ff[k]) : 64'(pc_ff[k]);
      assign qs_in   = mag_s[59:28];
      assign qc_in   = mag_c[59:28];
      assign es_prod = {32'd0, qs_in} * SIN_RCP[k];
      assign ec_prod = {32'd0, qc_in} * COS_RCP[k];
      // reciprocal estimate is low by at most one: fix with one compare
      assign rs_prod = {32'd0, es_ff[k]} * SIN_DIV[k];
      assign rc_prod = {32'd0, ec_ff[k]} * COS_DIV[k];
      assign rem_s   = qs_ff[k] - rs_prod[31:0];
      assign rem_c   = qc_ff[k] - rc_prod[31:0];
      assign quo_s   = es_ff[k] + ((rem_s >= SIN_DIV[k][31:0]) ? 32'd1 : 32'd0);
      assign quo_c   = ec_ff[k] + ((rem_c >= COS_DIV[k][31:0]) ? 32'd1 : 32'd0);
      assign ts_in   = ns_ff[k] ? $signed(quo_s) : -$signed(quo_s);
      assign tc_in   = nc_ff[k] ? $signed(quo_c) : -$signed(quo_c);

      always_ff @(posedge clock) begin
         if (adv[3*k-2]) begin
            ps_ff[k] <= 64'(ts_ff[k-1]) * h2w;
            pc_ff[k] <= 64'(tc_ff[k-1]) * h2w;
            sa_ff[k] <= s_ff[k-1];
            ca_ff[k] <= c_ff[k-1];
            ha_ff[k] <= h2_ff[k-1];
         end
         if (adv[3*k-1]) begin
            qs_ff[k] <= qs_in;
            qc_ff[k] <= qc_in;
            es_ff[k] <= es_prod[63:32];
            ec_ff[k] <= ec_prod[63:32];
            ns_ff[k] <= ps_ff[k][63];
            nc_ff[k] <= pc_ff[k][63];
            sb_ff[k] <= sa_ff[k];
            cb_ff[k] <= ca_ff[k];
            hb_ff[k] <= ha_ff[k];
         end
         if (adv[3*k]) begin
            ts_ff[k] <= ts_in;
            tc_ff[k] <= tc_in;
            s_ff[k]  <= sb_ff[k] + ts_in;
            c_ff[k]  <= cb_ff[k] + tc_in;
            h2_ff[k] <= hb_ff[k];
         end
      end
   end

   assign sin_q = s_ff[NTERMS];
   assign cos_q = c_ff[NTERMS];

endmodule

// ----- rtl/trs_model_matrix_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_model_matrix_builder
// Model matrix T*R*S from position, Euler XYZ angles and axis scales.
// ----------------------------------------------------------------------------
// A request carries a Q16.16 position, three Q3.13 angles in radians and three
// Q8.16 scales; the response is the upper three rows of the model matrix in
// Q16.16, rotation columns scaled and saturated, translation column equal to
// the position. The block is a 38-stage pipeline with no state between
// requests: one request is taken every cycle unless req_stall is raised, and
// a new request may enter before earlier ones are through. The stages are
// those of the half-angle sine/cosine series (one setup stage plus three
// stages for each of ten terms: multiply, reciprocal multiply, correct and
// accumulate), followed by seven stages of quaternion and matrix arithmetic.
// Empty stages close up under a response stall, so requests keep flowing
// until every stage is full.
module trs_model_matrix_builder import trs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic signed [15:0]  req_angle_x,
   input  logic signed [15:0]  req_angle_y,
   input  logic signed [15:0]  req_angle_z,
   input  logic signed [23:0]  req_scale_x,
   input  logic signed [23:0]  req_scale_y,
   input  logic signed [23:0]  req_scale_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_m00,
   output logic signed [31:0]  rsp_m01,
   output logic signed [31:0]  rsp_m02,
   output logic signed [31:0]  rsp_m03,
   output logic signed [31:0]  rsp_m10,
   output logic signed [31:0]  rsp_m11,
   output logic signed [31:0]  rsp_m12,
   output logic signed [31:0]  rsp_m13,
   output logic signed [31:0]  rsp_m20,
   output logic signed [31:0]  rsp_m21,
   output logic signed [31:0]  rsp_m22,
   output logic signed [31:0]  rsp_m23
);

   localparam int QS = SC_LAT;   // first quaternion stage

   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] ok;
   pay_type         pay_ff [0:NSTG-1];
   pay_type         pay_in;

   logic signed [31:0] sx, cx, sy, cy, sz, cz;

   // quaternion and matrix stage registers
   logic signed [31:0] cxcy_ff, sxsy_ff, sxcy_ff, cxsy_ff, cz_ff, sz_ff;
   logic signed [31:0] pr_ff [0:7];
   logic signed [31:0] w_ff, x_ff, y_ff, z_ff;
   logic signed [31:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [33:0] r_ff [0:2][0:2];
   logic signed [39:0] mr_ff [0:2][0:2];
   logic signed [31:0] m_ff [0:2][0:2];

   // A stage may load when it is empty or its content moves on.
   always_comb begin
      ok[NSTG-1] = !v_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         ok[i] = !v_ff[i] || ok[i+1];
      end
   end

   assign req_stall = !ok[0];
   assign rsp_valid = v_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ok[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (ok[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Carry position and scale alongside the arithmetic.
   assign pay_in = '{pos_x: req_pos_x, pos_y: req_pos_y, pos_z: req_pos_z,
                     scale_x: req_scale_x, scale_y: req_scale_y, scale_z: req_scale_z};

   always_ff @(posedge clock) begin
      if (ok[0]) begin
         pay_ff[0] <= pay_in;
      end
      for (int i = 1; i < NSTG; i++) begin
         if (ok[i]) begin
            pay_ff[i] <= pay_ff[i-1];
         end
      end
   end

   trs_sincos u_sc_x (.clock(clock), .adv(ok[SC_LAT-1:0]), .angle(req_angle_x),
                      .sin_q(sx), .cos_q(cx));
   trs_sincos u_sc_y (.clock(clock), .adv(ok[SC_LAT-1:0]), .angle(req_angle_y),
                      .sin_q(sy), .cos_q(cy));
   trs_sincos u_sc_z (.clock(clock), .adv(ok[SC_LAT-1:0]), .angle(req_angle_z),
                      .sin_q(sz), .cos_q(cz));

   logic signed [23:0] sc_col [0:2];
   assign sc_col[0] = pay_ff[QS+4].scale_x;
   assign sc_col[1] = pay_ff[QS+4].scale_y;
   assign sc_col[2] = pay_ff[QS+4].scale_z;

   always_ff @(posedge clock) begin
      // pair products of the half-angle terms
      if (ok[QS]) begin
         cxcy_ff <= qmul(cx, cy);
         sxsy_ff <= qmul(sx, sy);
         sxcy_ff <= qmul(sx, cy);
         cxsy_ff <= qmul(cx, sy);
         cz_ff   <= cz;
         sz_ff   <= sz;
      end
      // triple products, left to right
      if (ok[QS+1]) begin
         pr_ff[0] <= qmul(cxcy_ff, cz_ff);
         pr_ff[1] <= qmul(sxsy_ff, sz_ff);
         pr_ff[2] <= qmul(sxcy_ff, cz_ff);
         pr_ff[3] <= qmul(cxsy_ff, sz_ff);
         pr_ff[4] <= qmul(cxsy_ff, cz_ff);
         pr_ff[5] <= qmul(sxcy_ff, sz_ff);
         pr_ff[6] <= qmul(cxcy_ff, sz_ff);
         pr_ff[7] <= qmul(sxsy_ff, cz_ff);
      end
      // quaternion
      if (ok[QS+2]) begin
         w_ff <= pr_ff[0] + pr_ff[1];
         x_ff <= pr_ff[2] - pr_ff[3];
         y_ff <= pr_ff[4] + pr_ff[5];
         z_ff <= pr_ff[6] - pr_ff[7];
      end
      if (ok[QS+3]) begin
         xx_ff <= qmul(x_ff, x_ff);
         yy_ff <= qmul(y_ff, y_ff);
         zz_ff <= qmul(z_ff, z_ff);
         xy_ff <= qmul(x_ff, y_ff);
         xz_ff <= qmul(x_ff, z_ff);
         yz_ff <= qmul(y_ff, z_ff);
         wx_ff <= qmul(w_ff, x_ff);
         wy_ff <= qmul(w_ff, y_ff);
         wz_ff <= qmul(w_ff, z_ff);
      end
      // rotation matrix
      if (ok[QS+4]) begin
         r_ff[0][0] <= 34'(QONE) - ((34'(yy_ff) + 34'(zz_ff)) <<< 1);
         r_ff[0][1] <= (34'(xy_ff) - 34'(wz_ff)) <<< 1;
         r_ff[0][2] <= (34'(xz_ff) + 34'(wy_ff)) <<< 1;
         r_ff[1][0] <= (34'(xy_ff) + 34'(wz_ff)) <<< 1;
         r_ff[1][1] <= 34'(QONE) - ((34'(xx_ff) + 34'(zz_ff)) <<< 1);
         r_ff[1][2] <= (34'(yz_ff) - 34'(wx_ff)) <<< 1;
         r_ff[2][0] <= (34'(xz_ff) - 34'(wy_ff)) <<< 1;
         r_ff[2][1] <= (34'(yz_ff) + 34'(wx_ff)) <<< 1;
         r_ff[2][2] <= 34'(QONE) - ((34'(xx_ff) + 34'(yy_ff)) <<< 1);
      end
      // scale each column
      if (ok[QS+5]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               mr_ff[i][j] <= 40'(qdiv28(64'(r_ff[i][j]) * 64'(sc_col[j])));
            end
         end
      end
      // saturate to the response range
      if (ok[QS+6]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               if (mr_ff[i][j] > 40'sd2147483647) begin
                  m_ff[i][j] <= 32'sh7fff_ffff;
               end else if (mr_ff[i][j] < -40'sd2147483648) begin
                  m_ff[i][j] <= 32'sh8000_0000;
               end else begin
                  m_ff[i][j] <= mr_ff[i][j][31:0];
               end
            end
         end
      end
   end

   assign rsp_m00 = m_ff[0][0];
   assign rsp_m01 = m_ff[0][1];
   assign rsp_m02 = m_ff[0][2];
   assign rsp_m10 = m_ff[1][0];
   assign rsp_m11 = m_ff[1][1];
   assign rsp_m12 = m_ff[1][2];
   assign rsp_m20 = m_ff[2][0];
   assign rsp_m21 = m_ff[2][1];
   assign rsp_m22 = m_ff[2][2];
   assign rsp_m03 = pay_ff[NSTG-1].pos_x;
   assign rsp_m13 = pay_ff[NSTG-1].pos_y;
   assign rsp_m23 = pay_ff[NSTG-1].pos_z;

endmodule

// ----- rtl/trs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks of the model matrix builder, bound to the top level.
// ----------------------------------------------------------------------------
module trs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_m00,
   input logic signed [31:0] rsp_m03
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // input backs up only behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

   // an empty or draining output slot keeps the input open
   a_no_stall_drain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled while output drains");

   // a held response stays valid and keeps its m00 and m03 values
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_m00) && $stable(rsp_m03)))
      else $error("held response changed");

endmodule

bind trs_model_matrix_builder trs_checker u_trs_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_m00(rsp_m00), .rsp_m03(rsp_m03));
